### rtl/core/hbcs_pkg.sv
package hbcs_pkg;

    localparam int         SPACE_BYTES      = 256;

    localparam logic [7:0] OFF_STATUS_HI    = 8'h07;
    localparam logic [7:0] OFF_BAR_LO       = 8'h12;
    localparam logic [7:0] OFF_BAR_HI       = 8'h13;
    localparam logic [7:0] OFF_CACHE_CTL    = 8'h42;
    localparam logic [7:0] OFF_SMRAM        = 8'h55;
    localparam logic [7:0] OFF_SHADOW_RD_LO = 8'h56;
    localparam logic [7:0] OFF_SHADOW_RD_HI = 8'h57;
    localparam logic [7:0] OFF_SHADOW_WR_LO = 8'h58;
    localparam logic [7:0] OFF_SHADOW_WR_HI = 8'h59;
    localparam logic [7:0] OFF_LOCK         = 8'h90;
    localparam logic [7:0] OFF_APERTURE     = 8'hbc;
    localparam logic [7:0] W1C_MASK         = 8'hf8;

    typedef struct packed {
        logic [7:0] mask;
        logic [7:0] lock;
    } t_wmask;

    // command from controller to datapath
    typedef struct packed {
        logic       clr;
        logic       load;
        logic       wr;
        logic [7:0] offset;
        logic [7:0] wdata;
    } t_cmd;

    function automatic logic [7:0] reset_value(input logic [7:0] off);
        logic [7:0] v;
        v = 8'h00;
        unique case (off)
            8'h00: v = 8'hb9;  8'h01: v = 8'h10;  8'h02: v = 8'h41;
            8'h03: v = 8'h15;  8'h04: v = 8'h06;  8'h06: v = 8'h10;
            8'h07: v = 8'h04;  8'h0b: v = 8'h06;  8'h0d: v = 8'h20;
            8'h2c: v = 8'hb9;  8'h2d: v = 8'h10;  8'h2e: v = 8'h41;
            8'h2f: v = 8'h15;  8'h34: v = 8'hb0;  8'h60: v = 8'h07;
            8'h61: v = 8'h40;  8'h89: v = 8'h20;  8'h8a: v = 8'h20;
            8'h91: v = 8'h13;  8'hb0: v = 8'h02;  8'hb1: v = 8'he0;
            8'hb2: v = 8'h10;  8'hb4: v = 8'h03;  8'hb5: v = 8'h02;
            8'hb7: v = 8'h1c;  8'hc8: v = 8'hbf;  8'hc9: v = 8'h0a;
            8'he0: v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_wmask write_mask(input logic [7:0] off);
        t_wmask r;
        r.lock = 8'h00;
        r.mask = 8'h00;
        if ((off >= 8'h2c && off <= 8'h2f) || off == 8'hb4 || off == 8'hb5 || off == 8'hb7)
            r.lock = 8'h01;
        else if (off == 8'h34)
            r.lock = 8'h02;
        else if (off >= 8'he0 && off <= 8'he7)
            r.lock = 8'h20;
        else if (off == 8'he8 || off == 8'he9)
            r.lock = 8'h04;
        unique case (off)
            8'h05: r.mask = 8'h01;
            8'h0d: r.mask = 8'hf8;
            8'h40, 8'h41: r.mask = 8'h7f;
            8'h43: r.mask = 8'hf7;
            8'h46: r.mask = 8'hf0;
            8'h4a: r.mask = 8'hf8;
            8'h50: r.mask = 8'h71;
            8'h54: r.mask = 8'h3c;
            8'h55: r.mask = 8'h1f;
            8'h5d: r.mask = 8'h17;
            8'h5f: r.mask = 8'hc1;
            8'h72: r.mask = 8'hc7;
            8'h73: r.mask = 8'h1f;
            8'h86: r.mask = 8'h0f;
            8'h8b: r.mask = 8'h3f;
            8'hb4: r.mask = 8'h03;
            8'hb5: r.mask = 8'h02;
            8'hb8, 8'hb9: r.mask = 8'h03;
            8'hbd: r.mask = 8'hf0;
            8'hc0: r.mask = 8'h90;
            8'hd1: r.mask = 8'hf1;
            8'he2: r.mask = 8'h3f;
            8'he3: r.mask = 8'hfe;
            8'he4: r.mask = 8'h03;
            8'he6: r.mask = 8'hc0;
            8'hea, 8'heb: r.mask = 8'hcf;
            8'hec: r.mask = 8'h3f;
            8'hee: r.mask = 8'h3e;
            8'hf3: r.mask = 8'h08;
            8'hf7: r.mask = 8'h43;
            8'h04, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h34,
            8'h42, 8'h44, 8'h45, 8'h47, 8'h48, 8'h49,
            8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
            8'h51, 8'h52, 8'h53,
            8'h56, 8'h57, 8'h58, 8'h59, 8'h5a, 8'h5b,
            8'h5c, 8'h5e, 8'h70, 8'h71,
            8'h84, 8'h85, 8'h87, 8'h88, 8'h89, 8'h8a,
            8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91,
            8'hb7, 8'hbb, 8'hbe, 8'hbf,
            8'hc1, 8'hc2, 8'hc3, 8'hc8, 8'hc9,
            8'hd2, 8'hd3, 8'he0, 8'he1, 8'he5, 8'he7,
            8'he8, 8'he9, 8'hed, 8'hef, 8'hf5, 8'hf6: r.mask = 8'hff;
            default: r.mask = (off >= 8'h60 && off <= 8'h6f) ? 8'hff : 8'h00;
        endcase
        return r;
    endfunction

    // bits 31:16 of the aperture mask
    function automatic logic [15:0] aperture_mask(input logic [3:0] code);
        logic [15:0] m;
        unique case (code)
            4'h1: m = 16'hfff0;
            4'h2: m = 16'hffe0;
            4'h3: m = 16'hffc0;
            4'h4: m = 16'hff80;
            4'h6: m = 16'hff00;
            4'h7: m = 16'hfe00;
            4'h8: m = 16'hfc00;
            4'h9: m = 16'hf800;
            4'ha: m = 16'hf000;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

### rtl/core/hbcs_datapath.sv
module hbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

module hbcs_datapath
    import hbcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_shadow_read_map,
    output logic [15:0] o_shadow_write_map,
    output logic [1:0]  o_smram_window,
    output logic        o_smram_open,
    output logic        o_smram_ext_lock,
    output logic        o_ext_cache_enable
);

    t_wmask      wm;
    logic [7:0]  wv;
    logic        allowed;
    logic [15:0] am;
    logic        ram_we;
    logic [7:0]  ram_wdata;
    logic [7:0]  ram_rdata;
    logic [7:0]  smr;

    // bytes that are decoded or read back at a fixed place live in registers
    logic [7:0]  r_status_hi, n_status_hi;
    logic [7:0]  r_bar_lo, n_bar_lo;
    logic [7:0]  r_bar_hi, n_bar_hi;
    logic [7:0]  r_aperture, n_aperture;
    logic [7:0]  r_lock, n_lock;
    logic [7:0]  r_smram, n_smram;
    logic [7:0]  r_srm_lo, n_srm_lo;
    logic [7:0]  r_srm_hi, n_srm_hi;
    logic [7:0]  r_swm_lo, n_swm_lo;
    logic [7:0]  r_swm_hi, n_swm_hi;
    logic [7:0]  r_cache_ctl, n_cache_ctl;
    logic [7:0]  r_fix_data, n_fix_data;
    logic        r_use_fix, n_use_fix;

    always_comb begin
        n_status_hi = r_status_hi;
        n_bar_lo    = r_bar_lo;
        n_bar_hi    = r_bar_hi;
        n_aperture  = r_aperture;
        n_lock      = r_lock;
        n_smram     = r_smram;
        n_srm_lo    = r_srm_lo;
        n_srm_hi    = r_srm_hi;
        n_swm_lo    = r_swm_lo;
        n_swm_hi    = r_swm_hi;
        n_cache_ctl = r_cache_ctl;
        wm = write_mask(i_cmd.offset);
        wv = i_cmd.wdata & wm.mask;
        allowed = (wm.mask != 8'h00) && (wm.lock == 8'h00 || (r_lock & wm.lock) != 8'h00);
        am = aperture_mask((i_cmd.offset == OFF_APERTURE) ? i_cmd.wdata[3:0]
                                                         : r_aperture[3:0]);
        ram_we = 1'b0;
        ram_wdata = wv;
        if (i_cmd.clr) begin
            ram_we = 1'b1;
            ram_wdata = reset_value(i_cmd.offset);
        end else if (i_cmd.wr) begin
            unique case (i_cmd.offset)
                OFF_STATUS_HI: n_status_hi = r_status_hi & ~(i_cmd.wdata & W1C_MASK);
                OFF_BAR_LO: begin
                    n_bar_lo = i_cmd.wdata & 8'hc0 & am[7:0];
                    n_bar_hi = r_bar_hi & am[15:8];
                end
                OFF_BAR_HI: begin
                    n_bar_lo = r_bar_lo & am[7:0];
                    n_bar_hi = i_cmd.wdata & am[15:8];
                end
                OFF_APERTURE: begin
                    n_aperture = i_cmd.wdata & 8'h0f;
                    n_bar_lo = r_bar_lo & am[7:0];
                    n_bar_hi = r_bar_hi & am[15:8];
                end
                OFF_LOCK:         n_lock = wv;
                OFF_SMRAM:        n_smram = wv;
                OFF_SHADOW_RD_LO: n_srm_lo = wv;
                OFF_SHADOW_RD_HI: n_srm_hi = wv;
                OFF_SHADOW_WR_LO: n_swm_lo = wv;
                OFF_SHADOW_WR_HI: n_swm_hi = wv;
                OFF_CACHE_CTL:    n_cache_ctl = wv;
                default:          ram_we = allowed;
            endcase
        end
        n_use_fix = 1'b1;
        n_fix_data = 8'h00;
        unique case (i_cmd.offset)
            OFF_STATUS_HI:    n_fix_data = n_status_hi;
            OFF_BAR_LO:       n_fix_data = n_bar_lo;
            OFF_BAR_HI:       n_fix_data = n_bar_hi;
            OFF_APERTURE:     n_fix_data = n_aperture;
            OFF_LOCK:         n_fix_data = n_lock;
            OFF_SMRAM:        n_fix_data = n_smram;
            OFF_SHADOW_RD_LO: n_fix_data = n_srm_lo;
            OFF_SHADOW_RD_HI: n_fix_data = n_srm_hi;
            OFF_SHADOW_WR_LO: n_fix_data = n_swm_lo;
            OFF_SHADOW_WR_HI: n_fix_data = n_swm_hi;
            OFF_CACHE_CTL:    n_fix_data = n_cache_ctl;
            default: begin
                // a byte just written is returned directly, the ram reads old data
                n_use_fix = ram_we;
                n_fix_data = ram_wdata;
            end
        endcase
    end

    hbcs_ram #(
        .WIDTH(8),
        .DEPTH(SPACE_BYTES)
    ) u_ram (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(i_cmd.offset),
        .i_wdata(ram_wdata),
        .i_re(i_cmd.load),
        .i_raddr(i_cmd.offset),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_hi <= reset_value(OFF_STATUS_HI);
            r_bar_lo    <= reset_value(OFF_BAR_LO);
            r_bar_hi    <= reset_value(OFF_BAR_HI);
            r_aperture  <= reset_value(OFF_APERTURE);
            r_lock      <= reset_value(OFF_LOCK);
            r_smram     <= reset_value(OFF_SMRAM);
            r_srm_lo    <= reset_value(OFF_SHADOW_RD_LO);
            r_srm_hi    <= reset_value(OFF_SHADOW_RD_HI);
            r_swm_lo    <= reset_value(OFF_SHADOW_WR_LO);
            r_swm_hi    <= reset_value(OFF_SHADOW_WR_HI);
            r_cache_ctl <= reset_value(OFF_CACHE_CTL);
        end else if (i_cmd.load) begin
            r_status_hi <= n_status_hi;
            r_bar_lo    <= n_bar_lo;
            r_bar_hi    <= n_bar_hi;
            r_aperture  <= n_aperture;
            r_lock      <= n_lock;
            r_smram     <= n_smram;
            r_srm_lo    <= n_srm_lo;
            r_srm_hi    <= n_srm_hi;
            r_swm_lo    <= n_swm_lo;
            r_swm_hi    <= n_swm_hi;
            r_cache_ctl <= n_cache_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fix_data <= n_fix_data;
            r_use_fix  <= n_use_fix;
        end
    end

    assign smr = r_smram;
    assign o_read_data = r_use_fix ? r_fix_data : ram_rdata;
    assign o_shadow_read_map = {r_srm_hi, r_srm_lo};
    assign o_shadow_write_map = {r_swm_hi, r_swm_lo};
    assign o_smram_window = !smr[0] ? 2'd0 :
                            (smr[3:2] == 2'b00) ? 2'd1 :
                            (smr[3:2] == 2'b01) ? 2'd2 :
                            (smr[3:2] == 2'b10) ? 2'd3 : 2'd0;
    assign o_smram_open = smr[1];
    assign o_smram_ext_lock = smr[4];
    assign o_ext_cache_enable = r_cache_ctl[0];

endmodule

### rtl/core/hbcs_ctrl.sv
module hbcs_ctrl
    import hbcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_wr,
    input  logic [7:0] i_offset,
    input  logic [7:0] i_wdata,
    input  logic       i_out_ready,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        ST_INIT  = 3'b001,
        ST_EMPTY = 3'b010,
        ST_FULL  = 3'b100
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_clr_addr;
    logic [7:0] n_clr_addr;
    logic       take;

    // a new request is taken once the held result leaves
    assign o_in_ready = (r_state == ST_EMPTY) || ((r_state == ST_FULL) && i_out_ready);
    assign take = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_FULL);

    always_comb begin
        o_cmd.clr = (r_state == ST_INIT);
        o_cmd.load = take;
        o_cmd.wr = take && i_wr;
        o_cmd.offset = (r_state == ST_INIT) ? r_clr_addr : i_offset;
        o_cmd.wdata = i_wdata;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            ST_INIT: begin
                n_clr_addr = r_clr_addr + 8'd1;
                n_state = (r_clr_addr == 8'hff) ? ST_EMPTY : ST_INIT;
            end
            ST_EMPTY: n_state = take ? ST_FULL : ST_EMPTY;
            ST_FULL:  n_state = (i_out_ready && !take) ? ST_EMPTY : ST_FULL;
            default:  n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_clr_addr <= 8'h00;
        end else begin
            r_state <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    a_full_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_out_valid) else $error("result lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr |-> o_cmd.load) else $error("write without load");
    a_no_take_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !o_in_ready) else $error("request during clearing");

endmodule

### rtl/core/host_bridge_config_space_unit.sv
// Host-bridge PCI configuration space: 256 bytes of register file. Each request is one byte
// read or masked write; the result returns the stored byte plus decoded shadow RAM, SMRAM and
// cache status. After reset a clearing pass over all 256 bytes loads the defaults, input not
// ready meanwhile. Then one request per cycle while results are taken, result valid in the
// next cycle in a held output register; a new request enters in the cycle the result leaves.
module host_bridge_config_space_unit
    import hbcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // offset[7:0], write_data[15:8]
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // read_data, shadow_read_map, shadow_write_map,
                                       // smram_window, smram_open, smram_ext_lock,
                                       // ext_cache_enable, zero fill
);

    t_cmd        cmd;
    logic [7:0]  read_data;
    logic [15:0] srm;
    logic [15:0] swm;
    logic [1:0]  win;
    logic        sopen;
    logic        slock;
    logic        cache;

    hbcs_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_wr(s_axis_tuser),
        .i_offset(s_axis_tdata[7:0]),
        .i_wdata(s_axis_tdata[15:8]),
        .i_out_ready(m_axis_tready),
        .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_cmd(cmd)
    );

    hbcs_datapath u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .o_read_data(read_data),
        .o_shadow_read_map(srm),
        .o_shadow_write_map(swm),
        .o_smram_window(win),
        .o_smram_open(sopen),
        .o_smram_ext_lock(slock),
        .o_ext_cache_enable(cache)
    );

    assign m_axis_tdata = {3'b000, cache, slock, sopen, win, swm, srm, read_data};

endmodule
